// ===== sv/ucc_pkg.sv =====
// Shared widths and code-point constants for the Unicode case converter.
package ucc_pkg;

    // Width of a code point on every port and register.
    localparam int unsigned CP_W = 21;

    typedef logic [CP_W-1:0] cp_t;

    // Direction codes carried by the kind field.
    localparam logic KIND_UPPER = 1'b0;
    localparam logic KIND_LOWER = 1'b1;

    // Code points that take part in special mappings.
    localparam cp_t CP_Y_DIAER_UP   = 21'h00178;
    localparam cp_t CP_DOTLESS_I    = 21'h00131;
    localparam cp_t CP_DOTTED_I     = 21'h00130;
    localparam cp_t CP_LONG_S       = 21'h0017F;
    localparam cp_t CP_ASCII_UP_I   = 21'h00049;
    localparam cp_t CP_ASCII_LO_I   = 21'h00069;
    localparam cp_t CP_ASCII_UP_S   = 21'h00053;
    localparam cp_t CP_Y_DIAER_LO   = 21'h000FF;

    // Offsets between the two cases of a letter.
    localparam cp_t OFS_LATIN   = 21'd32;
    localparam cp_t OFS_ARMEN   = 21'd48;
    localparam cp_t OFS_CYR_EXT = 21'd80;
    localparam cp_t OFS_PAIR    = 21'd1;

endpackage

// ===== sv/ucc_map.sv =====
// Combinational range-rule case mapping for one code point.
module ucc_map
    import ucc_pkg::*;
(
    input  logic kind,
    input  cp_t  code_point,
    output cp_t  mapped_point
);

    cp_t up_point;
    cp_t lo_point;

    // Mapping towards upper case.
    always_comb
    begin
        up_point = code_point;
        if (code_point inside {[21'h00061:21'h0007A], [21'h000E0:21'h000F6],
                               [21'h000F8:21'h000FE], [21'h00430:21'h0044F],
                               [21'h0FF41:21'h0FF5A]})
        begin
            up_point = code_point - OFS_LATIN;
        end
        else if (code_point == CP_Y_DIAER_LO)
        begin
            up_point = CP_Y_DIAER_UP;
        end
        else if (code_point == CP_DOTTED_I || code_point == CP_DOTLESS_I)
        begin
            up_point = CP_ASCII_UP_I;
        end
        else if (code_point == CP_LONG_S)
        begin
            up_point = CP_ASCII_UP_S;
        end
        else if (code_point[0] &&
                 (code_point inside {[21'h00100:21'h00137], [21'h0014A:21'h00177],
                                     [21'h00200:21'h00217], [21'h00460:21'h0047F]}))
        begin
            // Pairs with the capital at the even code point.
            up_point = code_point - OFS_PAIR;
        end
        else if (!code_point[0] &&
                 (code_point inside {[21'h00139:21'h00148], [21'h00179:21'h0017E]}))
        begin
            // Pairs with the capital at the odd code point.
            up_point = code_point - OFS_PAIR;
        end
        else if (code_point inside {[21'h00451:21'h0045C], [21'h0045E:21'h0045F]})
        begin
            up_point = code_point - OFS_CYR_EXT;
        end
        else if (code_point inside {[21'h00561:21'h00586]})
        begin
            up_point = code_point - OFS_ARMEN;
        end
    end

    // Mapping towards lower case.
    always_comb
    begin
        lo_point = code_point;
        if (code_point inside {[21'h00041:21'h0005A], [21'h000C0:21'h000D6],
                               [21'h000D8:21'h000DE], [21'h00410:21'h0042F],
                               [21'h0FF21:21'h0FF3A]})
        begin
            lo_point = code_point + OFS_LATIN;
        end
        else if (code_point == CP_DOTTED_I || code_point == CP_DOTLESS_I)
        begin
            lo_point = CP_ASCII_LO_I;
        end
        else if (code_point == CP_Y_DIAER_UP)
        begin
            lo_point = CP_Y_DIAER_LO;
        end
        else if (!code_point[0] &&
                 (code_point inside {[21'h00100:21'h00137], [21'h0014A:21'h00177],
                                     [21'h00200:21'h00217], [21'h00460:21'h0047F]}))
        begin
            lo_point = code_point + OFS_PAIR;
        end
        else if (code_point[0] &&
                 (code_point inside {[21'h00139:21'h00148], [21'h00179:21'h0017E]}))
        begin
            lo_point = code_point + OFS_PAIR;
        end
        else if (code_point inside {[21'h00401:21'h0040C], [21'h0040E:21'h0040F]})
        begin
            lo_point = code_point + OFS_CYR_EXT;
        end
        else if (code_point inside {[21'h00531:21'h00556], [21'h010A0:21'h010C5]})
        begin
            // Armenian and Georgian capitals.
            lo_point = code_point + OFS_ARMEN;
        end
    end

    // Direction select.
    assign mapped_point = (kind == KIND_LOWER) ? lo_point : up_point;

endmodule

// ===== sv/unicode_case_converter.sv =====
// Top level of the Unicode case converter: input register, mapping logic, result register.
//
// Each transfer takes one code point and a direction (kind 0 to upper case, 1 to lower
// case) when start is high; busy is never raised, so a new code point is taken in every
// cycle. The mapped code point appears on mapped_point with done high, one per transfer and
// in order, after passing through the input register and then the range-rule logic into the result register.
// The receiver cannot stall, so done must be sampled in the cycle it is high. Code points
// that no rule covers, including values above the Unicode range, come back unchanged.
module unicode_case_converter
    import ucc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            kind,
    input  logic [CP_W-1:0] code_point,
    output logic            done,
    output logic [CP_W-1:0] mapped_point
);

    logic in_valid_reg;
    logic kind_reg;
    cp_t  cp_reg;
    logic done_reg;
    cp_t  mapped_reg;
    cp_t  mapped_next;

    // The block keeps pace with every cycle.
    assign busy = 1'b0;

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg <= kind;
            cp_reg   <= code_point;
        end
    end

    ucc_map u_map (
        .kind         (kind_reg),
        .code_point   (cp_reg),
        .mapped_point (mapped_next)
    );

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            mapped_reg <= mapped_next;
        end
    end

    assign done         = done_reg;
    assign mapped_point = mapped_reg;

endmodule

// ===== sv/ucc_checker.sv =====
// Port-level checker for the Unicode case converter and its bind statement.
module ucc_checker
    import ucc_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            kind,
    input logic [CP_W-1:0] code_point,
    input logic            done,
    input logic [CP_W-1:0] mapped_point
);

    // Every accepted transfer yields a result.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted transfer produced no result");

    // No result appears without an accepted transfer.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !done)
        else $error("result without an accepted transfer");

    // Values beyond the Unicode range pass through unchanged.
    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && code_point > 21'h10FFFF) |->
            ##2 (mapped_point == $past(code_point, 2)))
        else $error("out-of-range code point was altered");

    // ASCII small letters map to their capitals.
    a_ascii_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_UPPER && code_point >= 21'h61 &&
         code_point <= 21'h7A) |->
            ##2 (mapped_point == $past(code_point, 2) - OFS_LATIN))
        else $error("ASCII letter not mapped to upper case");

endmodule

bind unicode_case_converter ucc_checker u_ucc_checker (.*);

// ===== bench/unicode_case_converter_tb.sv =====
// Self-checking testbench for the Unicode case converter.
`timescale 1ns / 1ps

module unicode_case_converter_tb;
    import ucc_pkg::*;

    // Run limit in clock cycles, far above the slowest correct run.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Cycles allowed after the last result before the run is closed.
    localparam int unsigned DRAIN_CYCLES = 8;
    // Mismatches reported in full before only counting.
    localparam int unsigned REPORT_MAX = 10;

    // One code point in flight and the case mapping predicted for it.
    typedef struct {
        logic dir;
        cp_t  point;
        cp_t  mapped;
    } case_transfer_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      kind;
    cp_t       code_point;
    logic      done;
    cp_t       mapped_point;

    case_transfer_t pending_maps[$];
    case_transfer_t oldest_map;
    int unsigned    failure_count;
    int unsigned    cycle_count;

    unicode_case_converter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .code_point   (code_point),
        .done         (done),
        .mapped_point (mapped_point)
    );

    // Free-running 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Upper-case mapping of a single code point.
    function automatic cp_t upper_point(cp_t c);
        if (c >= 21'h61 && c <= 21'h7A)
            return c - OFS_LATIN;
        if (c < 21'hE0)
            return c;
        if (c <= 21'hF6 || (c >= 21'hF8 && c <= 21'hFE))
            return c - OFS_LATIN;
        if (c == CP_Y_DIAER_LO)
            return CP_Y_DIAER_UP;
        if ((c >= 21'h100 && c < 21'h138) || (c > 21'h149 && c < 21'h178))
        begin
            if (c == CP_DOTTED_I || c == CP_DOTLESS_I)
                return CP_ASCII_UP_I;
            return c[0] ? c - OFS_PAIR : c;
        end
        if ((c >= 21'h139 && c < 21'h149) || (c > 21'h178 && c < 21'h17F))
            return c[0] ? c : c - OFS_PAIR;
        if (c == CP_LONG_S)
            return CP_ASCII_UP_S;
        if (c >= 21'h200 && c <= 21'h217)
            return c[0] ? c - OFS_PAIR : c;
        if (c >= 21'h430 && c <= 21'h44F)
            return c - OFS_LATIN;
        if ((c >= 21'h451 && c <= 21'h45C) || (c >= 21'h45E && c <= 21'h45F))
            return c - OFS_CYR_EXT;
        if (c >= 21'h460 && c <= 21'h47F)
            return c[0] ? c - OFS_PAIR : c;
        if (c >= 21'h561 && c < 21'h587)
            return c - OFS_ARMEN;
        if (c >= 21'hFF41 && c <= 21'hFF5A)
            return c - OFS_LATIN;
        return c;
    endfunction

    // Lower-case mapping of a single code point.
    function automatic cp_t lower_point(cp_t c);
        if (c >= 21'h41 && c <= 21'h5A)
            return c + OFS_LATIN;
        if (c < 21'hC0)
            return c;
        if (c <= 21'hD6 || (c >= 21'hD8 && c <= 21'hDE))
            return c + OFS_LATIN;
        if ((c >= 21'h100 && c < 21'h138) || (c > 21'h149 && c < 21'h178))
        begin
            if (c == CP_DOTTED_I || c == CP_DOTLESS_I)
                return CP_ASCII_LO_I;
            return c[0] ? c : c + OFS_PAIR;
        end
        if (c == CP_Y_DIAER_UP)
            return CP_Y_DIAER_LO;
        if ((c >= 21'h139 && c < 21'h149) || (c > 21'h178 && c < 21'h17F))
            return c[0] ? c + OFS_PAIR : c;
        if (c >= 21'h200 && c <= 21'h217)
            return c[0] ? c : c + OFS_PAIR;
        if ((c >= 21'h401 && c <= 21'h40C) || (c >= 21'h40E && c <= 21'h40F))
            return c + OFS_CYR_EXT;
        if (c >= 21'h410 && c <= 21'h42F)
            return c + OFS_LATIN;
        if (c >= 21'h460 && c <= 21'h47F)
            return c[0] ? c : c + OFS_PAIR;
        if (c >= 21'h531 && c <= 21'h556)
            return c + OFS_ARMEN;
        if (c >= 21'h10A0 && c <= 21'h10C5)
            return c + OFS_ARMEN;
        if (c >= 21'hFF21 && c <= 21'hFF3A)
            return c + OFS_LATIN;
        return c;
    endfunction

    // A random code point, weighted towards the blocks that carry case rules.
    function automatic cp_t pick_point();
        case ($urandom_range(0, 15))
            0:       return cp_t'($urandom_range(32'h40, 32'h7F));
            1:       return cp_t'($urandom_range(32'hBF, 32'h100));
            2, 3:    return cp_t'($urandom_range(32'hFF, 32'h180));
            4:       return cp_t'($urandom_range(32'h1FF, 32'h218));
            5, 6:    return cp_t'($urandom_range(32'h3FF, 32'h480));
            7:       return cp_t'($urandom_range(32'h52F, 32'h588));
            8:       return cp_t'($urandom_range(32'h109F, 32'h10C6));
            9:       return cp_t'($urandom_range(32'hFF1F, 32'hFF5C));
            10:      return cp_t'($urandom_range(0, 32'hFFFF));
            11:      return cp_t'($urandom_range(0, 32'h10FFFF));
            12:      return cp_t'($urandom_range(0, 32'h1FFFFF));
            default: return cp_t'($urandom_range(32'h100, 32'h17F));
        endcase
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Offer one code point and hold it until the block takes the transfer.
    task automatic send_point(input logic dir, input cp_t point);
        start      <= 1'b1;
        kind       <= dir;
        code_point <= point;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_maps.push_back('{dir, point,
                                 (dir == KIND_LOWER) ? lower_point(point) : upper_point(point)});
    endtask

    // Leave start low for a number of cycles, with noise on the data ports.
    task automatic idle_for(input int unsigned cycles);
        if (cycles > 0)
        begin
            start      <= 1'b0;
            kind       <= 1'($urandom_range(0, 1));
            code_point <= cp_t'($urandom_range(0, 32'h1FFFFF));
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Record one failure; only the first few are printed in full.
    task automatic note_failure(input string what, input case_transfer_t item, input cp_t got);
        failure_count++;
        if (failure_count <= REPORT_MAX)
            $display("%0t: %s: kind %0d code point %h expected %h got %h",
                     $time, what, item.dir, item.point, item.mapped, got);
    endtask

    // Extremes of both fields and each special mapping, back to back.
    task automatic test_special_mappings();
        send_point(KIND_UPPER, 21'h000000);
        send_point(KIND_LOWER, 21'h1FFFFF);
        send_point(KIND_LOWER, 21'h10FFFF);
        send_point(KIND_UPPER, 21'h00D800);
        send_point(KIND_UPPER, 21'h000061);
        send_point(KIND_LOWER, 21'h000041);
        send_point(KIND_UPPER, 21'h0000F7);
        send_point(KIND_UPPER, CP_DOTTED_I);
        send_point(KIND_UPPER, CP_DOTLESS_I);
        send_point(KIND_LOWER, CP_DOTTED_I);
        send_point(KIND_LOWER, CP_DOTLESS_I);
        send_point(KIND_UPPER, CP_LONG_S);
        send_point(KIND_LOWER, CP_LONG_S);
        send_point(KIND_UPPER, CP_Y_DIAER_LO);
        send_point(KIND_LOWER, CP_Y_DIAER_UP);
        send_point(KIND_UPPER, CP_Y_DIAER_UP);
        send_point(KIND_UPPER, 21'h000138);
        send_point(KIND_LOWER, 21'h000149);
        send_point(KIND_UPPER, 21'h000450);
        send_point(KIND_UPPER, 21'h00045D);
        send_point(KIND_LOWER, 21'h00040D);
        send_point(KIND_LOWER, 21'h0010A0);
        send_point(KIND_UPPER, 21'h0010D0);
        send_point(KIND_UPPER, 21'h00FF5A);
        send_point(KIND_LOWER, 21'h00FF21);
    endtask

    // Random code points in both directions, with bursts that never idle.
    task automatic test_random_points(input int unsigned count);
        int unsigned n;
        logic        burst;
        burst = 1'b0;
        for (n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_point(1'($urandom_range(0, 1)), pick_point());
            if (!burst)
                idle_for(pick_gap());
        end
    endtask

    // Compare every result with the oldest prediction still waiting.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_maps.size() == 0)
                note_failure("result with no transfer waiting", '{1'b0, '0, '0}, mapped_point);
            else
            begin
                oldest_map = pending_maps.pop_front();
                if (mapped_point !== oldest_map.mapped)
                    note_failure("mapping mismatch", oldest_map, mapped_point);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("unicode_case_converter_tb: FAIL");
            $finish;
        end
    end

    // Reset, then the tests in turn, then drain and report.
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        kind          = 1'b0;
        code_point    = '0;
        failure_count = 0;
        cycle_count   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_mappings();
        idle_for(pick_gap());
        test_random_points(1500);
        start <= 1'b0;

        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        // Predictions never matched by a result count as failures.
        failure_count += pending_maps.size();
        if (failure_count == 0)
            $display("unicode_case_converter_tb: PASS");
        else
            $display("unicode_case_converter_tb: FAIL");
        $finish;
    end

endmodule
